// ===== hdl/protobuf_wire_tokenizer_macros.svh =====
// Assertion macros used by the tokenizer checker.
`ifndef PROTOBUF_WIRE_TOKENIZER_MACROS_SVH
`define PROTOBUF_WIRE_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PWT_ASSERT_NOW(lbl, clk, rst_n, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PWT_ASSERT_NEXT(lbl, clk, rst_n, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hdl/pwt_pkg.sv =====
// Types and constants of the protobuf wire tokenizer.
package pwt_pkg;

  localparam int unsigned MaxVarintBytes       = 10;
  localparam int unsigned DefMaxGroupNesting   = 255;
  localparam int unsigned ByteIdxW             = 4;
  localparam int unsigned DepthW               = 8;

  // Wire types carried in the low bits of a tag.
  localparam logic [2:0] WIRE_VARINT  = 3'd0;
  localparam logic [2:0] WIRE_FIXED64 = 3'd1;
  localparam logic [2:0] WIRE_LENGTH  = 3'd2;
  localparam logic [2:0] WIRE_SGROUP  = 3'd3;
  localparam logic [2:0] WIRE_EGROUP  = 3'd4;
  localparam logic [2:0] WIRE_FIXED32 = 3'd5;
  localparam logic [2:0] WIRE_BAD6    = 3'd6;
  localparam logic [2:0] WIRE_BAD7    = 3'd7;

  typedef enum logic [3:0] {
    TK_TAG            = 4'd0,
    TK_VARINT         = 4'd1,
    TK_FIXED32        = 4'd2,
    TK_FIXED64        = 4'd3,
    TK_LENGTH         = 4'd4,
    TK_PAYLOAD        = 4'd5,
    TK_BADWIRE        = 4'd6,
    TK_UNMATCHED_END  = 4'd7,
    TK_TRUNCATED      = 4'd8,
    TK_DEPTH_OVERFLOW = 4'd9
  } tok_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    tok_kind_e          token_kind;
    logic [7:0]         field_number;
    logic [2:0]         wire_code;
    logic [7:0]         nesting_depth;
    logic [63:0]        value_raw;
    logic signed [31:0] value_int32;
    logic signed [63:0] value_zigzag64;
    logic signed [31:0] value_zigzag32;
    logic               payload_last;
  } out_item_t;

  // Token handed from the decoder to the result register.
  typedef struct packed {
    logic              have;
    tok_kind_e         kind;
    logic [7:0]        field_number;
    logic [2:0]        wire_code;
    logic [DepthW-1:0] nesting_depth;
    logic [63:0]       raw;
    logic              last;
  } tok_t;

endpackage

// ===== hdl/protobuf_wire_tokenizer.sv =====
// Top level of the protobuf wire-format tokenizer.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------
//  in      | input     | in_valid_i / in_ready_o   | in_item_i  (byte, end flag)
//  out     | output    | out_valid_o / out_ready_i | out_item_o (one token)
//
// One byte per clock while the output does not stall; a token shows in the result register
// once its byte moves on from the input register, and a byte that makes no token shows nothing.
// Parse state updates on the edge that moves the byte into the result stage.
// Reset clears all parse state and both valid flags; no clearing pass is needed.
// A stalled output holds the byte in the input register and blocks new bytes, even
// those that make no token; the cycle the stall releases takes a new byte again.
module protobuf_wire_tokenizer import pwt_pkg::*; #(
  parameter int unsigned MaxGroupNesting = DefMaxGroupNesting
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic     s1_valid_q, s1_valid_d;
  in_item_t s1_item_q;
  logic     out_free;
  logic     s1_adv;
  logic     in_load;
  tok_t     tok;

  // Advance the held byte whenever the result slot is free or draining.
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_load    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Capture the incoming item; hold it while the output stalls.
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      s1_item_q <= in_item_i;
    end
  end

  pwt_decoder #(
    .MaxGroupNesting(MaxGroupNesting)
  ) u_decoder (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(s1_adv),
    .item_i(s1_item_q),
    .tok_o (tok)
  );

  pwt_result_reg u_result (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (s1_adv),
    .tok_i      (tok),
    .out_ready_i(out_ready_i),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o)
  );

endmodule

// ===== hdl/pwt_decoder.sv =====
// Parse state registers and the one-byte decode step of the tokenizer.
module pwt_decoder import pwt_pkg::*; #(
  parameter int unsigned MaxGroupNesting = DefMaxGroupNesting
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_item_t item_i,
  output tok_t     tok_o
);

  localparam logic [2:0] PH_TAG     = 3'd0;
  localparam logic [2:0] PH_VARINT  = 3'd1;
  localparam logic [2:0] PH_FIX32   = 3'd2;
  localparam logic [2:0] PH_FIX64   = 3'd3;
  localparam logic [2:0] PH_LENGTH  = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;

  localparam logic [ByteIdxW-1:0] VarintLastIdx = ByteIdxW'(MaxVarintBytes - 1);

  logic [2:0]          phase_q, phase_d;
  logic [63:0]         acc_q, acc_d;
  logic [ByteIdxW-1:0] idx_q, idx_d;
  logic [2:0]          wire_q, wire_d;
  logic [7:0]          field_q, field_d;
  logic [63:0]         rem_q, rem_d;
  logic [DepthW-1:0]   depth_q, depth_d;

  logic [7:0]          b;
  logic [ByteIdxW-1:0] vidx;
  logic [5:0]          vshamt;
  logic [63:0]         vacc;
  logic                vdone;
  logic [2:0]          fidx;
  logic [63:0]         facc;
  logic                fdone;
  logic [63:0]         rem_dec;
  logic                open;
  tok_t                tok;

  assign b      = item_i.data_byte;
  assign vidx   = (idx_q > VarintLastIdx) ? VarintLastIdx : idx_q;
  assign vshamt = 6'(32'(vidx) * 32'd7);
  assign vacc   = acc_q | (64'(b[6:0]) << vshamt);
  assign vdone  = !b[7] || (vidx == VarintLastIdx);
  assign fidx   = idx_q[2:0];
  assign facc   = acc_q | (64'(b) << {fidx, 3'b000});
  assign fdone  = (phase_q == PH_FIX32) ? (fidx >= 3'd3) : (fidx == 3'd7);
  assign rem_dec = rem_q - 64'd1;

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    idx_d   = idx_q;
    wire_d  = wire_q;
    field_d = field_q;
    rem_d   = rem_q;
    depth_d = depth_q;

    tok.have          = 1'b0;
    tok.kind          = TK_TAG;
    tok.field_number  = field_q;
    tok.wire_code     = wire_q;
    tok.nesting_depth = '0;
    tok.raw           = '0;
    tok.last          = 1'b0;

    unique case (phase_q)
      PH_VARINT, PH_LENGTH: begin
        if (vdone) begin
          tok.have = 1'b1;
          tok.raw  = vacc;
          acc_d    = '0;
          idx_d    = '0;
          if (phase_q == PH_VARINT) begin
            tok.kind = TK_VARINT;
            phase_d  = PH_TAG;
          end else begin
            tok.kind = TK_LENGTH;
            rem_d    = vacc;
            phase_d  = (vacc == 64'd0) ? PH_TAG : PH_PAYLOAD;
          end
        end else begin
          acc_d = vacc;
          idx_d = vidx + 1'b1;
        end
      end
      PH_FIX32, PH_FIX64: begin
        if (fdone) begin
          tok.have = 1'b1;
          tok.raw  = facc;
          tok.kind = (phase_q == PH_FIX32) ? TK_FIXED32 : TK_FIXED64;
          acc_d    = '0;
          idx_d    = '0;
          phase_d  = PH_TAG;
        end else begin
          acc_d = facc;
          idx_d = ByteIdxW'(fidx) + 1'b1;
        end
      end
      PH_PAYLOAD: begin
        tok.have = 1'b1;
        tok.kind = TK_PAYLOAD;
        tok.raw  = 64'(b);
        rem_d    = rem_dec;
        if (rem_dec == 64'd0) begin
          tok.last = 1'b1;
          phase_d  = PH_TAG;
        end
      end
      default: begin
        // Tag phase; unused codes fall back to it.
        phase_d = PH_TAG;
        if (vdone) begin
          acc_d            = '0;
          idx_d            = '0;
          tok.have         = 1'b1;
          tok.raw          = vacc;
          tok.field_number = vacc[10:3];
          tok.wire_code    = vacc[2:0];
          field_d          = vacc[10:3];
          wire_d           = vacc[2:0];
          if (vacc[2:0] == WIRE_BAD6 || vacc[2:0] == WIRE_BAD7) begin
            tok.kind = TK_BADWIRE;
          end else if (vacc[2:0] == WIRE_SGROUP) begin
            if (depth_q >= DepthW'(MaxGroupNesting)) begin
              tok.kind = TK_DEPTH_OVERFLOW;
            end else begin
              depth_d = depth_q + 1'b1;
            end
          end else if (vacc[2:0] == WIRE_EGROUP) begin
            if (depth_q == '0) begin
              tok.kind = TK_UNMATCHED_END;
            end else begin
              depth_d = depth_q - 1'b1;
            end
          end else if (vacc[2:0] == WIRE_VARINT) begin
            phase_d = PH_VARINT;
          end else if (vacc[2:0] == WIRE_FIXED64) begin
            phase_d = PH_FIX64;
          end else if (vacc[2:0] == WIRE_FIXED32) begin
            phase_d = PH_FIX32;
          end else begin
            phase_d = PH_LENGTH;
          end
        end else begin
          acc_d = vacc;
          idx_d = vidx + 1'b1;
        end
      end
    endcase

    tok.nesting_depth = depth_d;

    if (item_i.end_of_stream) begin
      open = (phase_d != PH_TAG) || (idx_d != '0) || (depth_d != '0);
      if (open && !(tok.have && (tok.kind == TK_BADWIRE ||
                                 tok.kind == TK_UNMATCHED_END ||
                                 tok.kind == TK_DEPTH_OVERFLOW))) begin
        tok.have         = 1'b1;
        tok.kind         = TK_TRUNCATED;
        tok.raw          = '0;
        tok.last         = 1'b0;
        tok.field_number = field_d;
        tok.wire_code    = wire_d;
      end
      tok.nesting_depth = '0;
      phase_d = PH_TAG;
      acc_d   = '0;
      idx_d   = '0;
      wire_d  = '0;
      field_d = '0;
      rem_d   = '0;
      depth_d = '0;
    end else begin
      open = 1'b0;
    end
  end

  assign tok_o = tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      acc_q   <= '0;
      idx_q   <= '0;
      wire_q  <= '0;
      field_q <= '0;
      rem_q   <= '0;
      depth_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      idx_q   <= idx_d;
      wire_q  <= wire_d;
      field_q <= field_d;
      rem_q   <= rem_d;
      depth_q <= depth_d;
    end
  end

endmodule

// ===== hdl/pwt_result_reg.sv =====
// Result register of the tokenizer and the derived value views.
module pwt_result_reg import pwt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  tok_t      tok_i,
  input  logic      out_ready_i,
  output logic      free_o,
  output logic      out_valid_o,
  output out_item_t out_item_o
);

  logic valid_q, valid_d;
  tok_t tok_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = tok_i.have;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload holds unless a new token is loaded.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tok_q <= tok_i;
    end
  end

  assign out_valid_o               = valid_q;
  assign out_item_o.token_kind     = tok_q.kind;
  assign out_item_o.field_number   = tok_q.field_number;
  assign out_item_o.wire_code      = tok_q.wire_code;
  assign out_item_o.nesting_depth  = tok_q.nesting_depth;
  assign out_item_o.value_raw      = tok_q.raw;
  assign out_item_o.value_int32    = signed'(tok_q.raw[31:0]);
  assign out_item_o.value_zigzag64 = signed'({1'b0, tok_q.raw[63:1]} ^ {64{tok_q.raw[0]}});
  assign out_item_o.value_zigzag32 = signed'({1'b0, tok_q.raw[31:1]} ^ {32{tok_q.raw[0]}});
  assign out_item_o.payload_last   = tok_q.last;

endmodule

// ===== hdl/pwt_checker.sv =====
// Port-level checker for the tokenizer and its bind.
`include "protobuf_wire_tokenizer_macros.svh"

module pwt_checker import pwt_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  logic out_stall;
  logic last_seen;
  logic is_payload;
  logic trunc_seen;
  logic trunc_clean;
  logic bad_seen;
  logic bad_code;

  assign out_stall   = out_valid_o && !out_ready_i;
  assign last_seen   = out_valid_o && out_item_o.payload_last;
  assign is_payload  = (out_item_o.token_kind == TK_PAYLOAD);
  assign trunc_seen  = out_valid_o && (out_item_o.token_kind == TK_TRUNCATED);
  assign trunc_clean = (out_item_o.nesting_depth == '0) && (out_item_o.value_raw == '0);
  assign bad_seen    = out_valid_o && (out_item_o.token_kind == TK_BADWIRE);
  assign bad_code    = (out_item_o.wire_code == WIRE_BAD6) ||
                       (out_item_o.wire_code == WIRE_BAD7);

  // A stalled result holds.
  `PWT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_item_o))

  // Only payload bytes carry the last flag.
  `PWT_ASSERT_NOW(a_last_payload, clk_i, rst_ni, last_seen, is_payload)

  // A truncation token ends the stream: depth and value are cleared.
  `PWT_ASSERT_NOW(a_trunc_clean, clk_i, rst_ni, trunc_seen, trunc_clean)

  // A bad wire token reports one of the reserved wire types.
  `PWT_ASSERT_NOW(a_badwire_type, clk_i, rst_ni, bad_seen, bad_code)

endmodule

bind protobuf_wire_tokenizer pwt_checker u_pwt_checker (.*);

// ===== tb/protobuf_wire_tokenizer_tb.sv =====
// Testbench for the protobuf wire tokenizer: byte-stream stimulus, token predictor, checker.
module protobuf_wire_tokenizer_tb;
  import pwt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Same limit the DUT is built with, so the depth overflow is reachable.
  localparam int unsigned GroupLimit = DefMaxGroupNesting;
  // Cycles of the long receiver hold-off used to fill the block and stall its input.
  localparam int unsigned LongHold = 300;
  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned QuietLimit = 2000;

  // Decoder phases of the predictor; unused codes behave as a tag phase.
  typedef enum logic [2:0] {
    PS_TAG,
    PS_VARINT,
    PS_FIX32,
    PS_FIX64,
    PS_LENGTH,
    PS_PAYLOAD
  } parse_phase_e;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  // Predictor state, kept apart from the DUT.
  parse_phase_e phase;
  logic [63:0]  acc;
  logic [3:0]   byte_idx;
  logic [2:0]   cur_wire;
  logic [7:0]   cur_field;
  logic [63:0]  remaining;
  logic [7:0]   group_depth;

  out_item_t   pending_tokens[$];  // tokens predicted and not yet seen at the output
  logic [7:0]  msg_bytes[$];       // encoded message under construction
  int unsigned bytes_sent = 0;
  int unsigned mismatches = 0;
  bit          idle_on = 1'b1;
  int unsigned hold_requests = 0;

  always #1 clk_i = ~clk_i;

  protobuf_wire_tokenizer #(
    .MaxGroupNesting(GroupLimit)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  // Return every piece of parse state to its power-up value.
  function automatic void clear_parse_state();
    phase       = PS_TAG;
    acc         = '0;
    byte_idx    = '0;
    cur_wire    = '0;
    cur_field   = '0;
    remaining   = '0;
    group_depth = '0;
  endfunction

  // Fold one varint byte into the accumulator; report 1 once the varint is done.
  // The tenth byte closes the varint whatever its continuation bit says.
  function automatic bit varint_absorb(input logic [7:0] b);
    int unsigned k;
    k = (byte_idx > MaxVarintBytes - 1) ? MaxVarintBytes - 1 : byte_idx;
    acc |= 64'(b[6:0]) << (7 * k);
    if (!b[7] || k + 1 >= MaxVarintBytes) return 1'b1;
    byte_idx = 4'(k + 1);
    return 1'b0;
  endfunction

  // Advance the predictor by one byte; return 1 when the byte yields a token.
  function automatic bit tokenize_byte(input logic [7:0] b, input logic eos,
                                       output out_item_t tok);
    bit          have;
    tok_kind_e   kind;
    logic [63:0] raw;
    logic        last;
    logic [7:0]  fn;
    logic [2:0]  wt;
    int unsigned nbytes;
    int unsigned k;
    bit          open;
    have = 1'b0;
    kind = TK_TAG;
    raw  = '0;
    last = 1'b0;
    fn   = cur_field;
    wt   = cur_wire;
    case (phase)
      PS_VARINT, PS_LENGTH: begin
        if (varint_absorb(b)) begin
          raw      = acc;
          have     = 1'b1;
          acc      = '0;
          byte_idx = '0;
          if (phase == PS_VARINT) begin
            kind  = TK_VARINT;
            phase = PS_TAG;
          end else begin
            kind      = TK_LENGTH;
            remaining = raw;
            // A zero length has no payload: go straight back to tags.
            phase     = (raw == 64'd0) ? PS_TAG : PS_PAYLOAD;
          end
        end
      end
      PS_FIX32, PS_FIX64: begin
        nbytes = (phase == PS_FIX32) ? 4 : 8;
        k      = byte_idx[2:0];
        // Little-endian: each byte lands one octet higher.
        acc |= 64'(b) << (8 * k);
        if (k + 1 >= nbytes) begin
          raw      = acc;
          kind     = (phase == PS_FIX32) ? TK_FIXED32 : TK_FIXED64;
          have     = 1'b1;
          acc      = '0;
          byte_idx = '0;
          phase    = PS_TAG;
        end else begin
          byte_idx = 4'(k + 1);
        end
      end
      PS_PAYLOAD: begin
        raw  = 64'(b);
        kind = TK_PAYLOAD;
        have = 1'b1;
        remaining = remaining - 64'd1;
        if (remaining == 64'd0) begin
          last  = 1'b1;
          phase = PS_TAG;
        end
      end
      default: begin
        phase = PS_TAG;
        if (varint_absorb(b)) begin
          raw       = acc;
          acc       = '0;
          byte_idx  = '0;
          // Keep only the low 8 bits of the field number.
          fn        = raw[10:3];
          wt        = raw[2:0];
          cur_field = fn;
          cur_wire  = wt;
          have      = 1'b1;
          kind      = TK_TAG;
          case (wt)
            WIRE_VARINT:  phase = PS_VARINT;
            WIRE_FIXED64: phase = PS_FIX64;
            WIRE_LENGTH:  phase = PS_LENGTH;
            WIRE_FIXED32: phase = PS_FIX32;
            WIRE_SGROUP: begin
              // Saturate the depth and flag the overflow.
              if (group_depth >= GroupLimit) kind = TK_DEPTH_OVERFLOW;
              else group_depth++;
            end
            WIRE_EGROUP: begin
              if (group_depth == 0) kind = TK_UNMATCHED_END;
              else group_depth--;
            end
            default: kind = TK_BADWIRE;
          endcase
        end
      end
    endcase

    if (eos) begin
      // Report truncation for anything left open, unless an error token already won.
      open = (phase != PS_TAG) || (byte_idx != 0) || (group_depth != 0);
      if (open && !(have && (kind == TK_BADWIRE || kind == TK_UNMATCHED_END ||
                             kind == TK_DEPTH_OVERFLOW))) begin
        have = 1'b1;
        kind = TK_TRUNCATED;
        raw  = '0;
        last = 1'b0;
        fn   = cur_field;
        wt   = cur_wire;
      end
      clear_parse_state();
    end

    tok.token_kind     = kind;
    tok.field_number   = fn;
    tok.wire_code      = wt;
    tok.nesting_depth  = group_depth;
    tok.value_raw      = raw;
    tok.value_int32    = raw[31:0];
    tok.value_zigzag64 = {1'b0, raw[63:1]} ^ {64{raw[0]}};
    tok.value_zigzag32 = {1'b0, raw[31:1]} ^ {32{raw[0]}};
    tok.payload_last   = last;
    return have;
  endfunction

  // ---------------------------------------------------------------------------
  // Message encoding
  // ---------------------------------------------------------------------------

  // Append v as a varint; pad with extra continuation bytes to make it overlong.
  function automatic void put_varint(input logic [63:0] v, input int unsigned extra);
    int unsigned n;
    logic [63:0] t;
    n = 1;
    t = v >> 7;
    while (t != 0) begin
      n++;
      t = t >> 7;
    end
    n += extra;
    for (int unsigned i = 0; i < n; i++) begin
      msg_bytes.push_back({1'(i + 1 < n), v[6:0]});
      v = v >> 7;
    end
  endfunction

  function automatic void put_tag(input logic [31:0] fn, input logic [2:0] wt);
    put_varint((64'(fn) << 3) | 64'(wt), 0);
  endfunction

  function automatic void put_fixed(input logic [63:0] v, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) msg_bytes.push_back(v[8*i +: 8]);
  endfunction

  // Spread values over all magnitudes, from a few bits to the full 64.
  function automatic logic [63:0] rand_value();
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  // Mix small field numbers with large ones whose high bits get truncated.
  function automatic logic [31:0] rand_field_number();
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 15);
    return $urandom >> $urandom_range(3, 31);
  endfunction

  // Build a mostly well-formed message with random content, some errors and noise.
  function automatic void build_message();
    int unsigned open_groups;
    int unsigned nfields;
    int unsigned pick;
    int unsigned len;
    logic [31:0] fn;
    open_groups = 0;
    msg_bytes.delete();
    nfields = $urandom_range(1, 6);
    repeat (nfields) begin
      pick = $urandom_range(0, 99);
      fn   = rand_field_number();
      if (pick < 30) begin
        put_tag(fn, WIRE_VARINT);
        put_varint(rand_value(), ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
      end else if (pick < 42) begin
        put_tag(fn, WIRE_FIXED32);
        put_fixed(rand_value(), 4);
      end else if (pick < 54) begin
        put_tag(fn, WIRE_FIXED64);
        put_fixed(rand_value(), 8);
      end else if (pick < 72) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 16) : $urandom_range(0, 4);
        put_tag(fn, WIRE_LENGTH);
        put_varint(64'(len), ($urandom_range(0, 7) == 0) ? 1 : 0);
        repeat (len) msg_bytes.push_back(8'($urandom));
      end else if (pick < 82) begin
        put_tag(fn, WIRE_SGROUP);
        open_groups++;
      end else if (pick < 92) begin
        // Close a group when one is open, otherwise provoke an unmatched end.
        put_tag(fn, WIRE_EGROUP);
        if (open_groups > 0) open_groups--;
      end else if (pick < 96) begin
        put_tag(fn, ($urandom_range(0, 1) == 0) ? WIRE_BAD6 : WIRE_BAD7);
      end else begin
        repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom));
      end
    end
    // Leave groups open now and then so the stream ends mid-nesting.
    if ($urandom_range(0, 3) != 0) begin
      while (open_groups > 0) begin
        put_tag(rand_field_number(), WIRE_EGROUP);
        open_groups--;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offer one item and wait for its handshake; predict its token on acceptance.
  // Entered at a rising edge; valid may drop for an idle gap before it is raised.
  task automatic push_byte(input logic [7:0] b, input logic eos);
    out_item_t tok;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{data_byte: b, end_of_stream: eos};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (tokenize_byte(b, eos, tok)) pending_tokens.push_back(tok);
    bytes_sent++;
  endtask

  // Send the first n bytes of the message, marking the last one as end of stream.
  task automatic send_message(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_byte(msg_bytes[i], 1'(i + 1 == n));
  endtask

  // Receiver: random stall bursts while idling is on, plus requested long hold-offs.
  initial begin : ready_gen
    int unsigned stall_left;
    int unsigned holds_served;
    stall_left   = 0;
    holds_served = 0;
    out_ready_i  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        stall_left   = LongHold - 1;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left   = $urandom_range(0, 11);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare every accepted token with the oldest prediction.
  always @(posedge clk_i) begin : token_checker
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_tokens.size() == 0) begin
        $error("token with no prediction pending: kind %0d", out_item_o.token_kind);
        mismatches++;
      end else begin
        want = pending_tokens.pop_front();
        check_field("token_kind", 64'(want.token_kind), 64'(out_item_o.token_kind));
        check_field("field_number", 64'(want.field_number), 64'(out_item_o.field_number));
        check_field("wire_code", 64'(want.wire_code), 64'(out_item_o.wire_code));
        check_field("nesting_depth", 64'(want.nesting_depth),
                    64'(out_item_o.nesting_depth));
        check_field("value_raw", want.value_raw, out_item_o.value_raw);
        check_field("value_int32", 64'(want.value_int32), 64'(out_item_o.value_int32));
        check_field("value_zigzag64", want.value_zigzag64, out_item_o.value_zigzag64);
        check_field("value_zigzag32", 64'(want.value_zigzag32),
                    64'(out_item_o.value_zigzag32));
        check_field("payload_last", 64'(want.payload_last), 64'(out_item_o.payload_last));
      end
    end
  end

  // Abort when neither channel moves for too long.
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet;
    if (!rst_ni) begin
      quiet = 0;
    end else if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QuietLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // One stream touching every token kind but fixed64 and depth overflow, and corner cases of the decoder.
  task automatic test_directed_tokens();
    msg_bytes = '{
      // varint field, ten 0xFF bytes: overlong cap and all-ones value
      8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      // fixed32 holding the most negative 32-bit value
      8'h0D, 8'h00, 8'h00, 8'h00, 8'h80,
      // zero length, then a one-byte payload
      8'h12, 8'h00, 8'h1A, 8'h01, 8'hFF,
      // start and end group, then an end group with nothing open
      8'h23, 8'h24, 8'h2C,
      // both bad wire types
      8'h36, 8'h3F,
      // fixed64 cut short by the end of stream
      8'h09, 8'h01
    };
    send_message(msg_bytes.size());
  endtask

  // Nest to the limit, overflow, and end the stream on an overflowing start group.
  // Hold the receiver off meanwhile so the block fills and stalls its input.
  task automatic test_group_depth_limit();
    hold_requests++;
    msg_bytes.delete();
    repeat (GroupLimit + 1) msg_bytes.push_back(8'h0B);
    msg_bytes.push_back(8'h0C);
    msg_bytes.push_back(8'h0B);
    msg_bytes.push_back(8'h0B);
    send_message(msg_bytes.size());
  endtask

  // Random messages until n more items have gone in; cut some short.
  task automatic test_random_messages(input int unsigned n);
    int unsigned target;
    int unsigned cut;
    target = bytes_sent + n;
    while (bytes_sent < target) begin
      build_message();
      cut = ($urandom_range(0, 6) == 0) ? $urandom_range(1, msg_bytes.size())
                                        : msg_bytes.size();
      send_message(cut);
    end
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_steady_stream(input int unsigned n);
    idle_on = 1'b0;
    test_random_messages(n);
  endtask

  initial begin : run
    in_valid_i = 1'b0;
    in_item_i  = '0;
    rst_ni     = 1'b0;
    clear_parse_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_tokens();
    test_group_depth_limit();
    test_random_messages(280);
    test_steady_stream(150);

    // Drop valid, drain the remaining tokens, then give the pipeline time to settle.
    in_valid_i <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
